// ===== rtl/ethernet_rx_deframer_crc32_core_defines.svh =====
// Assertion macros for the receive deframer top level.
`ifndef ETHERNET_RX_DEFRAMER_CRC32_CORE_DEFINES_SVH
`define ETHERNET_RX_DEFRAMER_CRC32_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ERDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ERDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/erdc_pkg.sv =====
// Types, constants and the CRC-32 byte step for the receive deframer.
package erdc_pkg;

  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [7:0]  BCAST_BYTE = 8'hFF;

  localparam int DELAY_LEN = 4;
  localparam int SRC_START = 6;
  localparam int TYPE_LO   = 12;
  localparam int TYPE_HI   = 13;
  localparam int MIN_FRAME = 18;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FCS   = 2'd2,
    ST_ADDR  = 2'd3
  } status_t;

  typedef struct packed {
    logic         kind;
    logic [7:0]   payload_byte;
    status_t      status;
    logic [15:0]  frame_type;
    logic [47:0]  sender_address;
    logic         run_last;
  } result_t;

  // Results of one accepted byte: cnt items, item0 first.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    item0;
    result_t    item1;
  } push_t;

  // Reflected CRC-32 update over one byte, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/erdc_frame.sv =====
// Per-byte frame parser: header capture, delay line, CRC and status.
module erdc_frame #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        data_byte,
  input  logic              frame_end,
  input  logic [47:0]       station_address,
  output erdc_pkg::push_t   push
);
  import erdc_pkg::*;

  localparam logic [COUNT_BITS-1:0] IDX_DELAY = COUNT_BITS'(DELAY_LEN);
  localparam logic [COUNT_BITS-1:0] IDX_SRC   = COUNT_BITS'(SRC_START);
  localparam logic [COUNT_BITS-1:0] IDX_TLO   = COUNT_BITS'(TYPE_LO);
  localparam logic [COUNT_BITS-1:0] IDX_THI   = COUNT_BITS'(TYPE_HI);
  localparam logic [COUNT_BITS-1:0] IDX_MIN   = COUNT_BITS'(MIN_FRAME);
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};

  logic [31:0]           crc_r, crc_nxt;
  logic [7:0]            dly_r [DELAY_LEN];
  logic [7:0]            dly_nxt [DELAY_LEN];
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  own_r, own_nxt;
  logic                  bc_r, bc_nxt;
  logic [15:0]           type_r, type_nxt;
  logic [47:0]           sender_r, sender_nxt;

  logic [7:0]  want;
  logic [31:0] rx_fcs;
  status_t     st;
  result_t     pay_item, st_item;
  logic        pay_en;

  function automatic logic [7:0] addr_byte(input logic [47:0] a, input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0:    r = a[47:40];
      3'd1:    r = a[39:32];
      3'd2:    r = a[31:24];
      3'd3:    r = a[23:16];
      3'd4:    r = a[15:8];
      3'd5:    r = a[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  assign want = addr_byte(station_address, cnt_r[2:0]);

  always_comb begin
    crc_nxt    = crc_r;
    cnt_nxt    = cnt_r;
    own_nxt    = own_r;
    bc_nxt     = bc_r;
    type_nxt   = type_r;
    sender_nxt = sender_r;
    for (int i = 0; i < DELAY_LEN; i++) dly_nxt[i] = dly_r[i];
    pay_en   = 1'b0;
    st       = ST_OK;
    rx_fcs   = 32'h0;
    pay_item = '0;
    st_item  = '0;
    push     = '0;

    if (acc) begin
      // Advance the CRC with the byte leaving the delay line.
      if (cnt_r >= IDX_DELAY) begin
        crc_nxt = crc_byte(crc_r, dly_r[DELAY_LEN-1]);
        pay_en  = (cnt_r >= IDX_MIN);
      end
      dly_nxt[0] = data_byte;
      for (int i = 1; i < DELAY_LEN; i++) dly_nxt[i] = dly_r[i-1];

      if (cnt_r < IDX_SRC) begin
        if (data_byte != want)       own_nxt = 1'b0;
        if (data_byte != BCAST_BYTE) bc_nxt  = 1'b0;
      end else if (cnt_r < IDX_TLO) begin
        sender_nxt = {sender_r[39:0], data_byte};
      end else if (cnt_r == IDX_TLO) begin
        type_nxt[7:0] = data_byte;
      end else if (cnt_r == IDX_THI) begin
        type_nxt[15:8] = data_byte;
      end

      if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + 1'b1;

      pay_item.kind         = KIND_PAYLOAD;
      pay_item.payload_byte = dly_r[DELAY_LEN-1];

      rx_fcs = {dly_nxt[0], dly_nxt[1], dly_nxt[2], dly_nxt[3]};
      priority if (cnt_nxt < IDX_MIN)    st = ST_SHORT;
      else if (rx_fcs != ~crc_nxt)       st = ST_FCS;
      else if (!own_nxt && !bc_nxt)      st = ST_ADDR;
      else                               st = ST_OK;

      st_item.kind           = KIND_STATUS;
      st_item.status         = st;
      st_item.frame_type     = type_nxt;
      st_item.sender_address = sender_nxt;
      st_item.run_last       = 1'b1;

      push.cnt   = {1'b0, pay_en} + {1'b0, frame_end};
      push.item0 = pay_en ? pay_item : st_item;
      push.item1 = st_item;

      // Drop all frame state once the status is out.
      if (frame_end) begin
        crc_nxt    = CRC_INIT;
        cnt_nxt    = '0;
        own_nxt    = 1'b1;
        bc_nxt     = 1'b1;
        type_nxt   = '0;
        sender_nxt = '0;
        for (int i = 0; i < DELAY_LEN; i++) dly_nxt[i] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_INIT;
      cnt_r    <= '0;
      own_r    <= 1'b1;
      bc_r     <= 1'b1;
      type_r   <= '0;
      sender_r <= '0;
      for (int i = 0; i < DELAY_LEN; i++) dly_r[i] <= 8'h00;
    end else begin
      crc_r    <= crc_nxt;
      cnt_r    <= cnt_nxt;
      own_r    <= own_nxt;
      bc_r     <= bc_nxt;
      type_r   <= type_nxt;
      sender_r <= sender_nxt;
      for (int i = 0; i < DELAY_LEN; i++) dly_r[i] <= dly_nxt[i];
    end
  end

endmodule

// ===== rtl/erdc_out_fifo.sv =====
// Result queue: takes up to two items a cycle, hands out one.
module erdc_out_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  erdc_pkg::push_t               push,
  input  logic                          pop,
  output erdc_pkg::result_t             head,
  output logic                          head_valid,
  output logic                          room2,
  output logic [erdc_pkg::CNT_BITS-1:0] level
);
  import erdc_pkg::*;

  result_t             slot_r [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [PTR_BITS-1:0] wr_p1;

  assign wr_p1      = wr_r + 1'b1;
  assign head       = slot_r[rd_r];
  assign head_valid = (cnt_r != '0);
  assign room2      = (cnt_r <= CNT_BITS'(FIFO_DEPTH - 2));
  assign level      = cnt_r;

  always_comb begin
    wr_nxt  = wr_r + PTR_BITS'(push.cnt);
    rd_nxt  = rd_r + PTR_BITS'(pop);
    cnt_nxt = cnt_r + CNT_BITS'(push.cnt) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) slot_r[wr_r]  <= push.item0;
    if (push.cnt == 2'd2) slot_r[wr_p1] <= push.item1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/ethernet_rx_deframer_crc32_core.sv =====
// Top level of the Ethernet receive deframer with CRC-32 frame check.
//
// Input stream: one frame byte per transfer on in_tdata, in_tlast on the
// final (FCS) byte; no preamble. Result stream: payload bytes (out_tuser 0)
// and one status item per frame (out_tuser 1, out_tlast 1) carrying the
// status, type and sender address. Downstream drops the payload of a frame
// unless its status is ok.
// Throughput: one byte per cycle while the result queue has room; each input
// transfer is handled by the frame parser, whose results enter a four-entry
// result queue; the queue head drives the output port.
// Order: a payload byte leaves the parser four input bytes after it came in
// (the FCS delay line) and shows on the output in the cycle after that input
// transfer, if the queue is empty. The status item enters the queue with the
// transfer of the last byte, behind any payload byte that transfer released,
// which goes out first.
// Stall: the result queue keeps taking bytes while its head waits;
// in_tready drops when fewer than two entries are free.
// Reset: synchronous, active low; clears the frame state, empties the queue
// and sets station address to zero. cfg_wr_en writes the address at once.
`include "ethernet_rx_deframer_crc32_core_defines.svh"

module ethernet_rx_deframer_crc32_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // frame_end
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [7:0] payload_byte, [9:8] status,
                                  // [25:10] frame_type, [73:26] sender_address
  output logic        out_tuser,  // kind
  output logic        out_tlast,  // run_last
  // Configuration
  input  logic        cfg_wr_en,
  input  logic [47:0] cfg_wr_data // station_address
);
  import erdc_pkg::*;

  logic [47:0]         station_r;
  logic                in_acc;
  logic                out_acc;
  logic                room2;
  push_t               push;
  result_t             head;
  logic [CNT_BITS-1:0] level;

  // Hold the station address; a write applies to the destination bytes still to come.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= '0;
    end else if (cfg_wr_en) begin
      station_r <= cfg_wr_data;
    end
  end

  // Accept a byte only with room for a payload byte and a status item.
  assign in_tready = rst_n && room2;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  erdc_frame #(
    .COUNT_BITS (COUNT_BITS)
  ) u_frame (
    .clk             (clk),
    .rst_n           (rst_n),
    .acc             (in_acc),
    .data_byte       (in_tdata),
    .frame_end       (in_tlast),
    .station_address (station_r),
    .push            (push)
  );

  erdc_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_acc),
    .head       (head),
    .head_valid (out_tvalid),
    .room2      (room2),
    .level      (level)
  );

  assign out_tdata = {6'b0, head.sender_address, head.frame_type, head.status,
                      head.payload_byte};
  assign out_tuser = head.kind;
  assign out_tlast = head.run_last;

  `ERDC_ASSERT_NOW(a_level_bound, 1'b1, level <= CNT_BITS'(FIFO_DEPTH), "result queue overflow")
  `ERDC_ASSERT_NOW(a_ready_room, in_tready, level <= CNT_BITS'(FIFO_DEPTH - 2), "ready without room")
  `ERDC_ASSERT_NOW(a_status_last, out_tvalid, out_tuser == out_tlast, "status item and last differ")
  `ERDC_ASSERT_NEXT(a_status_out, in_acc && in_tlast, out_tvalid, "status item not queued")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the Ethernet receive deframer with CRC-32 frame check.
module testbench;
  import erdc_pkg::*;

  localparam int CNT_W       = 8;      // byte counter width given to the block
  localparam int SETTLE      = 8;      // cycles to let the parser and result queue go quiet
  localparam int LONG_HOLD   = 60;     // receiver hold-off that fills the result queue
  localparam int PHASE_BYTES = 270;    // minimum random bytes per traffic phase
  localparam int LONG_FRAME  = 260;    // longer than the byte counter can count
  localparam int MAX_SHOWN   = 100;    // mismatch lines printed before going quiet

  // One byte as it travels on the input channel.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;     // [7:0] data_byte
  logic        in_tlast = 1'b0;      // frame_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;            // [7:0] payload_byte, [9:8] status,
                                     // [25:10] frame_type, [73:26] sender_address
  logic        out_tuser;            // kind
  logic        out_tlast;            // run_last
  logic        cfg_wr_en = 1'b0;
  logic [47:0] cfg_wr_data = 48'h0;  // station_address

  ethernet_rx_deframer_crc32_core #(
    .COUNT_BITS(CNT_W)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Stimulus and checking state
  // ---------------------------------------------------------------------------
  wire_byte_t  rx_wire[$];        // bytes waiting to go out on the input channel
  wire_byte_t  on_wire;           // byte currently offered
  bit          offering = 1'b0;   // on_wire is being offered and not yet taken
  bit          in_taken = 1'b0;   // input transfer seen at the last rising edge
  int          send_idle_pct = 36;
  int          recv_idle_pct = 81;
  int          hold_asked = 0;    // bumped by the sequencer to ask for a hold-off
  int          hold_served = 0;
  int          hold_left = 0;
  int          bytes_sent = 0;
  int          mismatches = 0;

  logic [7:0]  body[$];           // frame under construction, FCS not yet added
  wire_byte_t  frame_q[$];        // finished frame, ready to queue for the wire

  // Frame check model: own copy of the deframer state.
  result_t     want_results[$];   // results still owed by the block, oldest first
  logic [47:0] station = 48'h0;
  logic [31:0] crc_acc = CRC_INIT;
  logic [7:0]  dly [0:3] = '{default: 8'h00};
  logic [CNT_W-1:0] nbytes = '0;
  bit          own_ok = 1'b1;
  bit          bcast_ok = 1'b1;
  logic [15:0] ety = 16'h0;
  logic [47:0] esrc = 48'h0;

  // ---------------------------------------------------------------------------
  // Clock, run limit
  // ---------------------------------------------------------------------------
  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop: a healthy run ends well within this.
  initial begin
    #2_000_000;
    $display("FAIL ethernet_rx_deframer_crc32_core");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Frame check model
  // ---------------------------------------------------------------------------

  // Reflected CRC-32, one byte folded in at once and shifted out LSB first.
  function automatic logic [31:0] fcs_step(input logic [31:0] acc, input logic [7:0] d);
    logic [31:0] r;
    r = acc ^ {24'h0, d};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  task automatic clear_frame();
    crc_acc  = CRC_INIT;
    dly      = '{default: 8'h00};
    nbytes   = '0;
    own_ok   = 1'b1;
    bcast_ok = 1'b1;
    ety      = 16'h0;
    esrc     = 48'h0;
  endtask

  // Advance the model by one received byte and queue the results it owes.
  task automatic deframe_byte(input logic [7:0] d, input logic last);
    result_t     r;
    int          idx;
    logic [31:0] rx_fcs;
    idx = int'(nbytes);
    // The byte leaving the four-byte FCS delay line feeds the CRC; past the
    // header and delay it is also a payload byte.
    if (idx >= DELAY_LEN) begin
      crc_acc = fcs_step(crc_acc, dly[3]);
      if (idx >= MIN_FRAME) begin
        r = '0;
        r.kind = KIND_PAYLOAD;
        r.payload_byte = dly[3];
        want_results.push_back(r);
      end
    end
    dly[3] = dly[2];
    dly[2] = dly[1];
    dly[1] = dly[0];
    dly[0] = d;
    // Header: destination compare, sender capture, type little-endian.
    if (idx < SRC_START) begin
      if (d != station[47 - 8 * idx -: 8]) own_ok = 1'b0;
      if (d != BCAST_BYTE) bcast_ok = 1'b0;
    end else if (idx < TYPE_LO) begin
      esrc = {esrc[39:0], d};
    end else if (idx == TYPE_LO) begin
      ety[7:0] = d;
    end else if (idx == TYPE_HI) begin
      ety[15:8] = d;
    end
    // Saturate the byte count; long frames keep flowing.
    if (nbytes != '1) nbytes++;
    if (last) begin
      rx_fcs = {dly[0], dly[1], dly[2], dly[3]};
      r = '0;
      r.kind = KIND_STATUS;
      r.run_last = 1'b1;
      r.frame_type = ety;
      r.sender_address = esrc;
      if (nbytes < MIN_FRAME) r.status = ST_SHORT;
      else if (rx_fcs != ~crc_acc) r.status = ST_FCS;
      else if (!own_ok && !bcast_ok) r.status = ST_ADDR;
      else r.status = ST_OK;
      want_results.push_back(r);
      clear_frame();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [79:0] got,
                                 input logic [79:0] want_v);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("%0t: %s mismatch, got %h, want %h", $time, what, got, want_v);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: apply register writes, check results, model accepted bytes.
  // Everything is sampled at the rising edge; the block's outputs still hold
  // their pre-edge values here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (cfg_wr_en) station = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (want_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 80'h0);
        end else begin
          want = want_results.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch("kind", 80'(out_tuser), 80'(want.kind));
          if (out_tdata[7:0] !== want.payload_byte)
            report_mismatch("payload_byte", 80'(out_tdata[7:0]), 80'(want.payload_byte));
          if (out_tdata[9:8] !== want.status)
            report_mismatch("status", 80'(out_tdata[9:8]), 80'(want.status));
          if (out_tdata[25:10] !== want.frame_type)
            report_mismatch("frame_type", 80'(out_tdata[25:10]), 80'(want.frame_type));
          if (out_tdata[73:26] !== want.sender_address)
            report_mismatch("sender_address", 80'(out_tdata[73:26]),
                            80'(want.sender_address));
          if (out_tdata[79:74] !== 6'h0)
            report_mismatch("tdata padding", 80'(out_tdata[79:74]), 80'h0);
          if (out_tlast !== want.run_last)
            report_mismatch("run_last", 80'(out_tlast), 80'(want.run_last));
        end
      end
      in_taken = in_tvalid && in_tready;
      if (in_taken) deframe_byte(in_tdata, in_tlast);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: hold each byte until it is taken, then maybe idle, then advance.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (offering && in_taken) offering = 1'b0;
      if (!offering && rx_wire.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        on_wire = rx_wire.pop_front();
        offering = 1'b1;
      end
      in_tvalid <= offering;
      in_tdata  <= on_wire.data;
      in_tlast  <= on_wire.last;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request so the result
  // queue fills and in_tready has to drop.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Frame building
  // ---------------------------------------------------------------------------
  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // Start a new frame body: destination, sender, type (low byte first).
  task automatic put_header(input logic [47:0] dest, input logic [47:0] src,
                            input logic [15:0] ety_v);
    body.delete();
    for (int i = 5; i >= 0; i--) body.push_back(dest[8 * i +: 8]);
    for (int i = 5; i >= 0; i--) body.push_back(src[8 * i +: 8]);
    body.push_back(ety_v[7:0]);
    body.push_back(ety_v[15:8]);
  endtask

  task automatic put_random(input int n);
    repeat (n) body.push_back(8'($urandom));
  endtask

  // Close the body, optionally with an FCS (damaged on request), into frame_q.
  task automatic ship(input bit with_fcs, input bit damage);
    logic [31:0] acc;
    logic [31:0] fcs;
    acc = CRC_INIT;
    foreach (body[i]) acc = fcs_step(acc, body[i]);
    fcs = ~acc;
    if (damage) fcs = fcs ^ (32'h1 << $urandom_range(31));
    if (with_fcs) begin
      for (int i = 0; i < 4; i++) body.push_back(fcs[8 * i +: 8]);
    end
    frame_q.delete();
    foreach (body[i])
      frame_q.push_back(wire_byte_t'{data: body[i], last: (i == body.size() - 1)});
  endtask

  task automatic send_frame();
    bytes_sent += frame_q.size();
    while (frame_q.size() != 0) rx_wire.push_back(frame_q.pop_front());
  endtask

  // Own address with one byte disturbed.
  function automatic logic [47:0] near_station();
    logic [47:0] a;
    int          k;
    a = station;
    k = $urandom_range(5);
    a[8 * k +: 8] = a[8 * k +: 8] ^ 8'($urandom_range(1, 255));
    return a;
  endfunction

  // Mostly well-formed frames with random content, the rest short frames,
  // damaged FCS, foreign destinations and plain noise.
  task automatic random_frame();
    int          pick;
    int          plen;
    int          n;
    logic [47:0] dest;
    pick = $urandom_range(99);
    plen = ($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(30);
    if (pick < 70) begin
      n = $urandom_range(19);
      if (n < 9) dest = station;
      else if (n < 15) dest = '1;
      else if (n < 18) dest = near_station();
      else dest = rand48();
      put_header(dest, rand48(), 16'($urandom));
      put_random(plen);
      ship(1'b1, pick >= 58);
    end else if (pick < 85) begin
      body.delete();
      n = $urandom_range(1, MIN_FRAME - 1);
      if (n > 4 && $urandom_range(1) == 1) begin
        put_random(n - 4);
        ship(1'b1, 1'b0);
      end else begin
        put_random(n);
        ship(1'b0, 1'b0);
      end
    end else begin
      body.delete();
      put_random($urandom_range(MIN_FRAME, 80));
      ship(1'b0, 1'b0);
    end
    send_frame();
  endtask

  task automatic fill_random();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) random_frame();
  endtask

  // Wait until every byte is taken and every owed result has come, then let
  // the parser settle so a register write cannot overtake a byte in flight.
  task automatic drain();
    while (rx_wire.size() != 0 || offering || want_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_station(input logic [47:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [47:0] addr_a;
    logic [47:0] addr_b;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- Directed frames, station address still at its reset value (zero) ---
    // Shortest good frame to the own address: ok, no payload.
    put_header(48'h0, 48'h0, 16'h0);
    ship(1'b1, 1'b0);
    send_frame();
    // Broadcast with all-ones fields and one all-ones payload byte.
    put_header('1, '1, '1);
    body.push_back(8'hFF);
    ship(1'b1, 1'b0);
    send_frame();
    // Payload bytes at both extremes.
    put_header(48'h0, rand48(), 16'h0800);
    repeat (4) begin
      body.push_back(8'h00);
      body.push_back(8'hFF);
    end
    ship(1'b1, 1'b0);
    send_frame();
    // Damaged FCS on an otherwise good frame.
    put_header(48'h0, rand48(), 16'h86DD);
    put_random(8);
    ship(1'b1, 1'b1);
    send_frame();
    // Foreign destination.
    put_header(48'h0000_0000_0001, rand48(), 16'h0806);
    put_random(3);
    ship(1'b1, 1'b0);
    send_frame();
    // Foreign destination and damaged FCS: the FCS error takes priority.
    put_header(rand48() | 48'h1, rand48(), 16'h0806);
    put_random(5);
    ship(1'b1, 1'b1);
    send_frame();
    // Almost broadcast: last destination byte off by one.
    put_header(48'hFFFF_FFFF_FFFE, rand48(), 16'h0);
    ship(1'b1, 1'b0);
    send_frame();
    // Short frames without FCS: one to five bytes, then thirteen and fourteen bytes.
    foreach (body[i]) body[i] = 8'h00;
    for (int n = 1; n <= 5; n++) begin
      body.delete();
      put_random(n);
      ship(1'b0, 1'b0);
      send_frame();
    end
    body.delete();
    put_random(TYPE_LO + 1);
    ship(1'b0, 1'b0);
    send_frame();
    body.delete();
    put_random(TYPE_HI + 1);
    ship(1'b0, 1'b0);
    send_frame();
    // Seventeen bytes carrying a valid FCS: still too short.
    body.delete();
    put_random(MIN_FRAME - 5);
    ship(1'b1, 1'b0);
    send_frame();
    drain();

    // New own address, then a frame to it.
    addr_a = rand48();
    write_station(addr_a);
    put_header(addr_a, rand48(), 16'($urandom));
    put_random(12);
    ship(1'b1, 1'b0);
    send_frame();
    drain();

    // Address change in the middle of the destination field: the first three
    // bytes match the old address, the rest must match the new one.
    addr_b = {~addr_a[47:24], 24'($urandom)};
    put_header({addr_a[47:24], addr_b[23:0]}, rand48(), 16'($urandom));
    put_random(6);
    ship(1'b1, 1'b0);
    repeat (3) rx_wire.push_back(frame_q.pop_front());
    drain();
    write_station(addr_b);
    send_frame();

    // --- Phase A: sender idles a little, receiver a lot ---
    fill_random();
    drain();

    // --- Phase B: the other way round, own address all ones ---
    send_idle_pct = 81;
    recv_idle_pct = 36;
    write_station('1);
    fill_random();
    drain();

    // --- Phase C: no idling, back-pressure burst, counter saturation ---
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_station(rand48());
    fill_random();
    @(posedge clk);
    hold_asked++;
    put_header(station, rand48(), 16'($urandom));
    put_random(LONG_FRAME - MIN_FRAME);
    ship(1'b1, 1'b0);
    send_frame();
    random_frame();
    drain();

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && want_results.size() == 0) begin
      $display("PASS ethernet_rx_deframer_crc32_core");
    end else begin
      $display("FAIL ethernet_rx_deframer_crc32_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/erdc_pkg.sv
rtl/erdc_frame.sv
rtl/erdc_out_fifo.sv
rtl/ethernet_rx_deframer_crc32_core.sv
sim/testbench.sv
